// ===== hdl/orbiting_source_stereo_panner_top_defines.svh =====
// ----------------------------------------------------------------------------
// Orbiting source stereo panner: assertion macros
// Concurrent check macros shared by the panner RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ORBITING_SOURCE_STEREO_PANNER_TOP_DEFINES_SVH
`define ORBITING_SOURCE_STEREO_PANNER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication on clk, idle during reset
`define OSP_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// next-cycle implication on clk, idle during reset
`define OSP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define OSP_ASSERT_IMPLY(lbl, ante, cons)
`define OSP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/osp_pkg.sv =====
// ----------------------------------------------------------------------------
// Orbiting source stereo panner: shared package
// Types, register indexes, law codes and polynomial constants.
// ----------------------------------------------------------------------------
package osp_pkg;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} unit_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	localparam int TRIG_TABLE_BITS_DEF = 10;

	localparam logic [2:0] REG_RATE   = 3'd0;
	localparam logic [2:0] REG_RADIUS = 3'd1;
	localparam logic [2:0] REG_SPREAD = 3'd2;
	localparam logic [2:0] REG_LAW    = 3'd3;
	localparam logic [2:0] REG_MGAIN  = 3'd4;

	localparam logic [1:0] LAW_POWER  = 2'd0;
	localparam logic [1:0] LAW_RATIO  = 2'd1;
	localparam logic [1:0] LAW_LINEAR = 2'd2;

	localparam logic [14:0] RESET_RADIUS = 15'd256;
	localparam logic [15:0] RESET_MGAIN  = 16'h8000;

	localparam logic [31:0] DIV_PHASE = 32'd1000000;
	localparam logic [31:0] DIV_PCT   = 32'd100;

	localparam logic [31:0] POLY_K9 = 32'd172272;

	// odd sine polynomial coefficients, Q30, applied from k7 down to k1
	function automatic logic [31:0] poly_coef(input logic [1:0] i);
		logic [31:0] k;
		unique case (i)
			2'd0: k = 32'd5026995;
			2'd1: k = 32'd85569306;
			2'd2: k = 32'd693598668;
			default: k = 32'd1686629713;
		endcase
		return k;
	endfunction

endpackage

// ===== hdl/osp_serial_unit.sv =====
// ----------------------------------------------------------------------------
// Orbiting source stereo panner: bit-serial arithmetic unit
// Shared shift-add multiply, restoring divide and two-bits-per-cycle square
// root, with a done pulse at the end.
// ----------------------------------------------------------------------------
module osp_serial_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  osp_pkg::unit_ctl_t ctl,
	input  logic [63:0]        a,
	input  logic [31:0]        b,
	output osp_pkg::unit_sts_t sts,
	output logic [63:0]        result
);

	osp_pkg::op_t op_q;
	logic         busy_q;
	logic         done_q;
	logic [5:0]   cnt_q;
	logic [63:0]  acc_q;
	logic [32:0]  aux_q;
	logic [31:0]  opd_q;

	logic [32:0] mul_sum;
	logic [32:0] div_t;
	logic        div_ge;
	logic [34:0] sq_t;
	logic [34:0] sq_trial;
	logic        sq_ge;
	logic [34:0] sq_diff;

	assign mul_sum  = {1'b0, acc_q[63:32]} + (aux_q[0] ? {1'b0, opd_q} : 33'd0);
	assign div_t    = {aux_q[31:0], acc_q[63]};
	assign div_ge   = div_t >= {1'b0, opd_q};
	assign sq_t     = {aux_q, acc_q[63:62]};
	assign sq_trial = {1'b0, opd_q, 2'b01};
	assign sq_ge    = sq_t >= sq_trial;
	assign sq_diff  = sq_t - sq_trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= osp_pkg::OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				op_q   <= ctl.op;
				cnt_q  <= (ctl.op == osp_pkg::OP_DIV) ? 6'd63 : 6'd31;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			unique case (ctl.op)
				osp_pkg::OP_MUL: begin
					acc_q <= '0;
					aux_q <= {1'b0, b};
					opd_q <= a[31:0];
				end
				osp_pkg::OP_DIV: begin
					acc_q <= a;
					aux_q <= '0;
					opd_q <= b;
				end
				default: begin
					acc_q <= a;
					aux_q <= '0;
					opd_q <= '0;
				end
			endcase
		end else if (busy_q) begin
			unique case (op_q)
				osp_pkg::OP_MUL: begin
					acc_q <= {mul_sum, acc_q[31:1]};
					aux_q <= {1'b0, aux_q[32:1]};
				end
				osp_pkg::OP_DIV: begin
					aux_q <= div_ge ? (div_t - {1'b0, opd_q}) : div_t;
					acc_q <= {acc_q[62:0], div_ge};
				end
				default: begin
					aux_q <= sq_ge ? sq_diff[32:0] : sq_t[32:0];
					opd_q <= {opd_q[30:0], sq_ge};
					acc_q <= {acc_q[61:0], 2'b00};
				end
			endcase
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign result   = (op_q == osp_pkg::OP_SQRT) ? {32'd0, opd_q} : acc_q;

endmodule

// ===== hdl/orbiting_source_stereo_panner_top.sv =====
// ----------------------------------------------------------------------------
// Orbiting source stereo panner: top level
// Orbits an emitter around the origin and turns its direction, seen from the
// listener, into left and right gains under a selectable pan law.
// ----------------------------------------------------------------------------
// One input beat is one control tick. The tick advances the orbit phase by
// elapsed_ms times the orbit rate, places the source on its circle (quarter
// sine polynomial, Q8.8 result), derives the pan from the x share of the
// source-to-listener direction, narrows it by the spread, applies the pan law
// and scales by source and master gain. Every product, quotient and root runs
// through one shared bit-serial unit, one operation at a time; a divide holds
// it longer than a multiply or a square root. The work in a tick, from the
// input beat to the output register, depends on the pan law (ratio law
// longest, linear and silent laws shortest), on whether the spread is in use,
// and on a zero distance, which skips the pan divide; the input is ready again
// in the cycle after the output register is loaded. One tick is in flight at a
// time; the finished result waits in an output register, so the next tick is
// taken while the previous result has not yet been drained.
// Configuration writes are taken at any cycle and must be issued while idle.
`include "orbiting_source_stereo_panner_top_defines.svh"

module orbiting_source_stereo_panner_top #(
	parameter int TRIG_TABLE_BITS = osp_pkg::TRIG_TABLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// elapsed_ms[9:0], listener_x[25:10], listener_y[41:26], listener_z[57:42],
	// source_gain[73:58], zero fill [79:74]
	input  logic [79:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// left_gain[15:0], right_gain[31:16], source_x[47:32], source_y[63:48]
	output logic [63:0] m_tdata
);

	localparam int QN = 1 << (TRIG_TABLE_BITS - 2);

	typedef enum logic [4:0] {
		S_IDLE, S_INC_MUL, S_INC_DIV, S_TRIG_SET, S_X2, S_POLY, S_SIN, S_POS,
		S_DIFF, S_SQ, S_LEN, S_PAN, S_SPR_MUL, S_SPR_DIV, S_LAW, S_L0_L, S_L0_R,
		S_L1_SQA, S_L1_SQB, S_L1_H, S_L1_DL, S_L1_DR, S_GAIN_A, S_GAIN_B, S_EMIT
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] rate_q;
	logic [14:0] radius_q;
	logic [6:0]  spread_q;
	logic [1:0]  law_q;
	logic [15:0] mgain_q;

	// tick state and latched input
	logic [31:0]        phase_q;
	logic [9:0]         el_q;
	logic signed [15:0] lx_q, ly_q, lz_q;
	logic [15:0]        g_q;

	// trig and position
	logic               tsel_q;
	logic               neg_q;
	logic [30:0]        x_q;
	logic [30:0]        x2_q;
	logic [31:0]        p_q;
	logic [1:0]         pk_q;
	logic [15:0]        tmag_q;
	logic signed [15:0] sx_q, sy_q;

	// direction, pan and weights
	logic [15:0] adx_q, ady_q, adz_q;
	logic        dxneg_q;
	logic [1:0]  sqi_q;
	logic [33:0] sq_q;
	logic [24:0] len_q;
	logic [16:0] pmag_q;
	logic        pneg_q;
	logic [21:0] prod_q;
	logic [23:0] lawa_q, lawb_q;
	logic [46:0] acc47_q;
	logic [23:0] h_q;
	logic [16:0] wl_q, wr_q;
	logic        gs_q;
	logic [30:0] gw_q;
	logic [15:0] lg_q;
	logic [15:0] rg_q;

	// output register
	logic        ov_q;
	logic [63:0] out_q;

	// serial unit handshake
	logic                iss_q;
	osp_pkg::unit_ctl_t  unit_ctl;
	osp_pkg::unit_sts_t  unit_sts;
	logic [63:0]         opa_q;
	logic [31:0]         opb_q;
	logic [63:0]         res;

	osp_serial_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (unit_ctl),
		.a      (opa_q),
		.b      (opb_q),
		.sts    (unit_sts),
		.result (res)
	);

	// trig index for the current pass: cosine sits a quarter turn ahead
	logic [TRIG_TABLE_BITS-1:0] idx_s, idx_t;
	logic [1:0]                 quad_s;
	logic [29:0]                xr_s;
	logic [30:0]                x_s;
	assign idx_s  = phase_q[31 -: TRIG_TABLE_BITS];
	assign idx_t  = tsel_q ? idx_s : idx_s + TRIG_TABLE_BITS'(QN);
	assign quad_s = idx_t[TRIG_TABLE_BITS-1 -: 2];
	assign xr_s   = {idx_t[TRIG_TABLE_BITS-3:0], {(32 - TRIG_TABLE_BITS){1'b0}}};
	assign x_s    = quad_s[0] ? (31'h4000_0000 - {1'b0, xr_s}) : {1'b0, xr_s};

	// sine rounding to Q1.15, capped at one
	logic [32:0] sin_r;
	logic [17:0] sin_m;
	logic [15:0] sin_cap;
	assign sin_r   = {1'b0, res[61:30]} + 33'd16384;
	assign sin_m   = sin_r[32:15];
	assign sin_cap = (sin_m > 18'd32768) ? 16'h8000 : sin_m[15:0];

	// position rounding and saturation
	logic [31:0]        pos_r;
	logic [16:0]        pos_m;
	logic signed [15:0] pos_v;
	assign pos_r = {1'b0, res[30:0]} + 32'd16384;
	assign pos_m = pos_r[31:15];
	always_comb begin
		if (neg_q) begin
			pos_v = (pos_m >= 17'd32768) ? 16'sh8000 : -$signed(pos_m[15:0]);
		end else begin
			pos_v = (pos_m > 17'd32767) ? 16'sh7fff : $signed(pos_m[15:0]);
		end
	end

	// differences to the listener
	logic signed [16:0] dx_s, dy_s;
	assign dx_s = {sx_q[15], sx_q} - {lx_q[15], lx_q};
	assign dy_s = {sy_q[15], sy_q} - {ly_q[15], ly_q};

	logic [15:0] sqop_s;
	always_comb begin
		unique case (sqi_q)
			2'd0: sqop_s = adx_q;
			2'd1: sqop_s = ady_q;
			default: sqop_s = adz_q;
		endcase
	end

	// pan views
	logic [6:0]  spr_s;
	logic [16:0] pan_s, om_s, op_s;
	logic [16:0] qcap_s;
	assign spr_s  = (spread_q > 7'd100) ? 7'd100 : spread_q;
	assign pan_s  = pneg_q ? (17'd0 - pmag_q) : pmag_q;
	assign om_s   = 17'h08000 - pan_s;
	assign op_s   = 17'h08000 + pan_s;
	assign qcap_s = (res > 64'd32768) ? 17'h08000 : res[16:0];

	// ratio law fold of the phase onto a half turn
	logic [31:0] fold_s, fb_s;
	assign fold_s = (phase_q <= 32'h8000_0000) ? phase_q : (32'd0 - phase_q);
	assign fb_s   = 32'h8000_0000 - fold_s;

	// final gain rounding and saturation
	logic [47:0] gv_r;
	logic [17:0] gv_m;
	logic [15:0] gv_cap;
	assign gv_r   = {1'b0, res[46:0]} + 48'h0000_2000_0000;
	assign gv_m   = gv_r[47:30];
	assign gv_cap = (gv_m > 18'd32768) ? 16'h8000 : gv_m[15:0];

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = ov_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			rate_q         <= '0;
			radius_q       <= osp_pkg::RESET_RADIUS;
			spread_q       <= '0;
			law_q          <= osp_pkg::LAW_POWER;
			mgain_q        <= osp_pkg::RESET_MGAIN;
			phase_q        <= '0;
			el_q           <= '0;
			lx_q           <= '0;
			ly_q           <= '0;
			lz_q           <= '0;
			g_q            <= '0;
			tsel_q         <= 1'b0;
			neg_q          <= 1'b0;
			x_q            <= '0;
			x2_q           <= '0;
			p_q            <= '0;
			pk_q           <= '0;
			tmag_q         <= '0;
			sx_q           <= '0;
			sy_q           <= '0;
			adx_q          <= '0;
			ady_q          <= '0;
			adz_q          <= '0;
			dxneg_q        <= 1'b0;
			sqi_q          <= '0;
			sq_q           <= '0;
			len_q          <= '0;
			pmag_q         <= '0;
			pneg_q         <= 1'b0;
			prod_q         <= '0;
			lawa_q         <= '0;
			lawb_q         <= '0;
			acc47_q        <= '0;
			h_q            <= '0;
			wl_q           <= '0;
			wr_q           <= '0;
			gs_q           <= 1'b0;
			gw_q           <= '0;
			lg_q           <= '0;
			rg_q           <= '0;
			ov_q           <= 1'b0;
			out_q          <= '0;
			iss_q          <= 1'b0;
			unit_ctl.start <= 1'b0;
			unit_ctl.op    <= osp_pkg::OP_MUL;
			opa_q          <= '0;
			opb_q          <= '0;
		end else begin
			unit_ctl.start <= 1'b0;
			if (ov_q && m_tready) begin
				ov_q <= 1'b0;
			end

			if (cfg_we) begin
				unique case (cfg_index)
					osp_pkg::REG_RATE:   rate_q   <= cfg_wdata;
					osp_pkg::REG_RADIUS: radius_q <= cfg_wdata[14:0];
					osp_pkg::REG_SPREAD: spread_q <= cfg_wdata[6:0];
					osp_pkg::REG_LAW:    law_q    <= cfg_wdata[1:0];
					osp_pkg::REG_MGAIN:  mgain_q  <= cfg_wdata;
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						el_q    <= s_tdata[9:0];
						lx_q    <= $signed(s_tdata[25:10]);
						ly_q    <= $signed(s_tdata[41:26]);
						lz_q    <= $signed(s_tdata[57:42]);
						g_q     <= s_tdata[73:58];
						tsel_q  <= 1'b0;
						gs_q    <= 1'b0;
						state_q <= S_INC_MUL;
					end
				end
				S_INC_MUL: begin
					if (!iss_q) begin
						iss_q <= 1'b1; unit_ctl.start <= 1'b1; unit_ctl.op <= osp_pkg::OP_MUL;
						opa_q <= {54'd0, el_q};
						opb_q <= {16'd0, rate_q};
					end else if (unit_sts.done) begin
						iss_q   <= 1'b0;
						prod_q  <= '0;
						opa_q   <= {res[31:0], 32'd0};
						state_q <= S_INC_DIV;
					end
				end
				S_INC_DIV: begin
					// phase step = elapsed * rate * 2^32 / 10^6, kept mod 2^32
					if (!iss_q) begin
						iss_q <= 1'b1; unit_ctl.start <= 1'b1; unit_ctl.op <= osp_pkg::OP_DIV;
						opb_q <= osp_pkg::DIV_PHASE;
					end else if (unit_sts.done) begin
						iss_q   <= 1'b0;
						phase_q <= phase_q + res[31:0];
						state_q <= S_TRIG_SET;
					end
				end
				S_TRIG_SET: begin
					x_q     <= x_s;
					neg_q   <= quad_s[1];
					state_q <= S_X2;
				end
				S_X2: begin
					if (!iss_q) begin
						iss_q <= 1'b1; unit_ctl.start <= 1'b1; unit_ctl.op <= osp_pkg::OP_MUL;
						opa_q <= {33'd0, x_q};
						opb_q <= {1'b0, x_q};
					end else if (unit_sts.done) begin
						iss_q   <= 1'b0;
						x2_q    <= res[60:30];
						p_q     <= osp_pkg::POLY_K9;
						pk_q    <= '0;
						state_q <= S_POLY;
					end
				end
				S_POLY: begin
					// Horner step: p = k - x^2 * p
					if (!iss_q) begin
						iss_q <= 1'b1; unit_ctl.start <= 1'b1; unit_ctl.op <= osp_pkg::OP_MUL;
						opa_q <= {33'd0, x2_q};
						opb_q <= p_q;
					end else if (unit_sts.done) begin
						iss_q <= 1'b0;
						p_q   <= osp_pkg::poly_coef(pk_q) - res[61:30];
						pk_q  <= pk_q + 2'd1;
						if (pk_q == 2'd3) begin
							state_q <= S_SIN;
						end
					end
				end
				S_SIN: begin
					if (!iss_q) begin
						iss_q <= 1'b1; unit_ctl.start <= 1'b1; unit_ctl.op <= osp_pkg::OP_MUL;
						opa_q <= {33'd0, x_q};
						opb_q <= p_q;
					end else if (unit_sts.done) begin
						iss_q   <= 1'b0;
						tmag_q  <= sin_cap;
						state_q <= S_POS;
					end
				end
				S_POS: begin
					if (!iss_q) begin
						iss_q <= 1'b1; unit_ctl.start <= 1'b1; unit_ctl.op <= osp_pkg::OP_MUL;
						opa_q <= {48'd0, tmag_q};
						opb_q <= {17'd0, radius_q};
					end else if (unit_sts.done) begin
						iss_q <= 1'b0;
						if (!tsel_q) begin
							sx_q    <= pos_v;
							tsel_q  <= 1'b1;
							state_q <= S_TRIG_SET;
						end else begin
							sy_q    <= pos_v;
							state_q <= S_DIFF;
						end
					end
				end
				S_DIFF: begin
					adx_q   <= dx_s[16] ? 16'(17'd0 - dx_s) : dx_s[15:0];
					ady_q   <= dy_s[16] ? 16'(17'd0 - dy_s) : dy_s[15:0];
					adz_q   <= lz_q[15] ? (16'd0 - lz_q) : lz_q;
					dxneg_q <= dx_s[16];
					sq_q    <= '0;
					sqi_q   <= '0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					if (!iss_q) begin
						iss_q <= 1'b1; unit_ctl.start <= 1'b1; unit_ctl.op <= osp_pkg::OP_MUL;
						opa_q <= {48'd0, sqop_s};
						opb_q <= {16'd0, sqop_s};
					end else if (unit_sts.done) begin
						iss_q <= 1'b0;
						sq_q  <= sq_q + res[33:0];
						sqi_q <= sqi_q + 2'd1;
						if (sqi_q == 2'd2) begin
							state_q <= S_LEN;
						end
					end
				end
				S_LEN: begin
					if (!iss_q) begin
						iss_q <= 1'b1; unit_ctl.start <= 1'b1; unit_ctl.op <= osp_pkg::OP_SQRT;
						opa_q <= {14'd0, sq_q, 16'd0};
						opb_q <= '0;
					end else if (unit_sts.done) begin
						iss_q   <= 1'b0;
						len_q   <= res[24:0];
						state_q <= S_PAN;
					end
				end
				S_PAN: begin
					// source on the listener: hold the pan at center
					if (!iss_q) begin
						if (len_q == '0) begin
							pmag_q  <= '0;
							pneg_q  <= 1'b0;
							state_q <= S_SPR_MUL;
						end else begin
							iss_q <= 1'b1; unit_ctl.start <= 1'b1; unit_ctl.op <= osp_pkg::OP_DIV;
							opa_q <= {25'd0, adx_q, 23'd0};
							opb_q <= {7'd0, len_q};
						end
					end else if (unit_sts.done) begin
						iss_q   <= 1'b0;
						pmag_q  <= qcap_s;
						pneg_q  <= dxneg_q;
						state_q <= S_SPR_MUL;
					end
				end
				S_SPR_MUL: begin
					if (!iss_q) begin
						if (spr_s == 7'd0) begin
							state_q <= S_LAW;
						end else begin
							iss_q <= 1'b1; unit_ctl.start <= 1'b1; unit_ctl.op <= osp_pkg::OP_MUL;
							opa_q <= {47'd0, pmag_q};
							opb_q <= {25'd0, 7'd100 - spr_s};
						end
					end else if (unit_sts.done) begin
						iss_q   <= 1'b0;
						prod_q  <= res[21:0];
						state_q <= S_SPR_DIV;
					end
				end
				S_SPR_DIV: begin
					if (!iss_q) begin
						iss_q <= 1'b1; unit_ctl.start <= 1'b1; unit_ctl.op <= osp_pkg::OP_DIV;
						opa_q <= {42'd0, prod_q};
						opb_q <= osp_pkg::DIV_PCT;
					end else if (unit_sts.done) begin
						iss_q   <= 1'b0;
						pmag_q  <= res[16:0];
						state_q <= S_LAW;
					end
				end
				S_LAW: begin
					priority case (law_q)
						osp_pkg::LAW_POWER: state_q <= S_L0_L;
						osp_pkg::LAW_RATIO: begin
							lawa_q  <= fold_s[31:8];
							lawb_q  <= fb_s[31:8];
							state_q <= S_L1_SQA;
						end
						osp_pkg::LAW_LINEAR: begin
							wl_q    <= {1'b0, om_s[16:1]};
							wr_q    <= 17'h08000 - {1'b0, om_s[16:1]};
							state_q <= S_GAIN_A;
						end
						default: begin
							wl_q    <= '0;
							wr_q    <= '0;
							state_q <= S_GAIN_A;
						end
					endcase
				end
				S_L0_L: begin
					if (!iss_q) begin
						iss_q <= 1'b1; unit_ctl.start <= 1'b1; unit_ctl.op <= osp_pkg::OP_SQRT;
						opa_q <= {33'd0, om_s, 14'd0};
					end else if (unit_sts.done) begin
						iss_q   <= 1'b0;
						wl_q    <= res[16:0];
						state_q <= S_L0_R;
					end
				end
				S_L0_R: begin
					if (!iss_q) begin
						iss_q <= 1'b1; unit_ctl.start <= 1'b1; unit_ctl.op <= osp_pkg::OP_SQRT;
						opa_q <= {33'd0, op_s, 14'd0};
					end else if (unit_sts.done) begin
						iss_q   <= 1'b0;
						wr_q    <= res[16:0];
						state_q <= S_GAIN_A;
					end
				end
				S_L1_SQA: begin
					if (!iss_q) begin
						iss_q <= 1'b1; unit_ctl.start <= 1'b1; unit_ctl.op <= osp_pkg::OP_MUL;
						opa_q <= {40'd0, lawa_q};
						opb_q <= {8'd0, lawa_q};
					end else if (unit_sts.done) begin
						iss_q   <= 1'b0;
						acc47_q <= res[46:0];
						state_q <= S_L1_SQB;
					end
				end
				S_L1_SQB: begin
					if (!iss_q) begin
						iss_q <= 1'b1; unit_ctl.start <= 1'b1; unit_ctl.op <= osp_pkg::OP_MUL;
						opa_q <= {40'd0, lawb_q};
						opb_q <= {8'd0, lawb_q};
					end else if (unit_sts.done) begin
						iss_q   <= 1'b0;
						acc47_q <= acc47_q + res[46:0];
						state_q <= S_L1_H;
					end
				end
				S_L1_H: begin
					if (!iss_q) begin
						iss_q <= 1'b1; unit_ctl.start <= 1'b1; unit_ctl.op <= osp_pkg::OP_SQRT;
						opa_q <= {17'd0, acc47_q};
					end else if (unit_sts.done) begin
						iss_q <= 1'b0;
						h_q   <= res[23:0];
						if (res[23:0] == '0) begin
							wl_q    <= '0;
							wr_q    <= '0;
							state_q <= S_GAIN_A;
						end else begin
							state_q <= S_L1_DL;
						end
					end
				end
				S_L1_DL: begin
					if (!iss_q) begin
						iss_q <= 1'b1; unit_ctl.start <= 1'b1; unit_ctl.op <= osp_pkg::OP_DIV;
						opa_q <= {25'd0, lawa_q, 15'd0};
						opb_q <= {8'd0, h_q};
					end else if (unit_sts.done) begin
						iss_q   <= 1'b0;
						wl_q    <= qcap_s;
						state_q <= S_L1_DR;
					end
				end
				S_L1_DR: begin
					if (!iss_q) begin
						iss_q <= 1'b1; unit_ctl.start <= 1'b1; unit_ctl.op <= osp_pkg::OP_DIV;
						opa_q <= {25'd0, lawb_q, 15'd0};
						opb_q <= {8'd0, h_q};
					end else if (unit_sts.done) begin
						iss_q   <= 1'b0;
						wr_q    <= qcap_s;
						state_q <= S_GAIN_A;
					end
				end
				S_GAIN_A: begin
					if (!iss_q) begin
						iss_q <= 1'b1; unit_ctl.start <= 1'b1; unit_ctl.op <= osp_pkg::OP_MUL;
						opa_q <= {48'd0, g_q};
						opb_q <= {15'd0, gs_q ? wr_q : wl_q};
					end else if (unit_sts.done) begin
						iss_q   <= 1'b0;
						gw_q    <= res[30:0];
						state_q <= S_GAIN_B;
					end
				end
				S_GAIN_B: begin
					if (!iss_q) begin
						iss_q <= 1'b1; unit_ctl.start <= 1'b1; unit_ctl.op <= osp_pkg::OP_MUL;
						opa_q <= {48'd0, mgain_q};
						opb_q <= {1'b0, gw_q};
					end else if (unit_sts.done) begin
						iss_q <= 1'b0;
						if (!gs_q) begin
							lg_q    <= gv_cap;
							gs_q    <= 1'b1;
							state_q <= S_GAIN_A;
						end else begin
							rg_q    <= gv_cap;
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					// hold until the output register is free
					if (!ov_q || m_tready) begin
						out_q[15:0]  <= lg_q;
						out_q[31:16] <= rg_q;
						out_q[47:32] <= sx_q;
						out_q[63:48] <= sy_q;
						ov_q         <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`OSP_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready)
	`OSP_ASSERT_IMPLY(a_no_restart, unit_ctl.start, !unit_sts.busy)
	`OSP_ASSERT_IMPLY(a_gain_range, m_tvalid, (m_tdata[15:0] <= 16'h8000) && (m_tdata[31:16] <= 16'h8000))

endmodule
